// ===== sv/bstm_pkg.sv =====
// ----------------------------------------------------------------------------
// bstm_pkg
// shared constants, sequencer states and write controls for the tree map
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bstm_pkg;

  // default sizes
  localparam int NODES_DEF      = 1024;
  localparam int KEY_BITS_DEF   = 16;
  localparam int VALUE_BITS_DEF = 16;

  // operation codes
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  // walk sequencer
  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_COMPARE,
    S_ATTACH,
    S_LINK,
    S_DONE
  } state_t;

  // node store write enables, one per field group
  typedef struct packed {
    logic key_value;
    logic left;
    logic right;
  } wr_ctrl_t;

endpackage

`default_nettype wire

// ===== sv/bstm_node_store.sv =====
// ----------------------------------------------------------------------------
// bstm_node_store
// node memories: key, value and child links, one write and one read a cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bstm_node_store #(
  parameter int NODES      = bstm_pkg::NODES_DEF,
  parameter int KEY_BITS   = bstm_pkg::KEY_BITS_DEF,
  parameter int VALUE_BITS = bstm_pkg::VALUE_BITS_DEF,
  parameter int ADDR_W     = $clog2(NODES),
  parameter int IDX_W      = $clog2(NODES + 1)
) (
  input  wire logic                   clk,
  input  wire logic                   rd_en,
  input  wire logic [ADDR_W-1:0]      rd_addr,
  output logic      [KEY_BITS-1:0]    rd_key,
  output logic      [VALUE_BITS-1:0]  rd_value,
  output logic      [IDX_W-1:0]       rd_left,
  output logic      [IDX_W-1:0]       rd_right,
  input  wire bstm_pkg::wr_ctrl_t     wr,
  input  wire logic [ADDR_W-1:0]      wr_addr,
  input  wire logic [KEY_BITS-1:0]    wr_key,
  input  wire logic [VALUE_BITS-1:0]  wr_value,
  input  wire logic [IDX_W-1:0]       wr_child
);
  import bstm_pkg::*;

  logic [KEY_BITS-1:0]   key_mem   [NODES];
  logic [VALUE_BITS-1:0] value_mem [NODES];
  logic [IDX_W-1:0]      left_mem  [NODES];
  logic [IDX_W-1:0]      right_mem [NODES];

  always_ff @(posedge clk) begin
    if (wr.key_value) begin
      key_mem[wr_addr]   <= wr_key;
      value_mem[wr_addr] <= wr_value;
    end
    if (wr.left) begin
      left_mem[wr_addr] <= wr_child;
    end
    if (wr.right) begin
      right_mem[wr_addr] <= wr_child;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_key   <= key_mem[rd_addr];
      rd_value <= value_mem[rd_addr];
      rd_left  <= left_mem[rd_addr];
      rd_right <= right_mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== sv/binary_search_tree_map_unit.sv =====
// ----------------------------------------------------------------------------
// binary_search_tree_map_unit
// unbalanced binary search tree mapping keys to value handles
// ----------------------------------------------------------------------------
// one input channel (operation, key, value) and one result channel
// (found, stored_value, full_res), both valid/stall. every input item gives
// exactly one result item. insert of a new key attaches a leaf; insert of a
// present key keeps the old value and reports it as found; insert into a
// full store is dropped with full_res set. lookup returns the held value.
// the walk reads one node per tree level through the single read port of
// the node store, each level taking a read state and a compare state. a
// hit ends at the compare of the matching node; a miss or full insert ends
// at the fetch that finds no node; a new-key insert writes the leaf, then
// links it into its parent (or makes it the root of an empty tree). the
// unit goes back to idle before the next item is taken.
// in_stall is high while an item is being walked. the result sits in an
// output register; while out_stall holds it, the finished walk waits in its
// last state and no new item is taken. reset empties the tree (root set to
// the none marker, node count zero); node memories need no clearing since
// only allocated nodes are ever read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module binary_search_tree_map_unit #(
  parameter int NODES      = bstm_pkg::NODES_DEF,
  parameter int KEY_BITS   = bstm_pkg::KEY_BITS_DEF,
  parameter int VALUE_BITS = bstm_pkg::VALUE_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic                  operation,
  input  wire logic [KEY_BITS-1:0]   key,
  input  wire logic [VALUE_BITS-1:0] value,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic                       found,
  output logic [VALUE_BITS-1:0]      stored_value,
  output logic                       full_res
);
  import bstm_pkg::*;

  localparam int ADDR_W = $clog2(NODES);
  localparam int IDX_W  = $clog2(NODES + 1);
  localparam logic [IDX_W-1:0] NONE = IDX_W'(NODES);

  state_t state, state_next;

  // item under work
  logic                  op_r;
  logic [KEY_BITS-1:0]   key_r;
  logic [VALUE_BITS-1:0] value_r;

  // walk registers
  logic [IDX_W-1:0] cur;
  logic [IDX_W-1:0] parent;
  logic             go_left;
  logic [IDX_W-1:0] root;
  logic [IDX_W-1:0] count;

  // pending result
  logic                  res_found;
  logic [VALUE_BITS-1:0] res_value;
  logic                  res_full;

  // node store port
  logic                  rd_en;
  logic [KEY_BITS-1:0]   rd_key;
  logic [VALUE_BITS-1:0] rd_value;
  logic [IDX_W-1:0]      rd_left;
  logic [IDX_W-1:0]      rd_right;
  wr_ctrl_t              wr;
  logic [ADDR_W-1:0]     wr_addr;
  logic [IDX_W-1:0]      wr_child;

  logic in_take;
  logic out_free;
  logic out_load;
  logic cur_live;
  logic hit;
  logic store_full;
  logic parent_none;

  assign in_take     = in_valid && !in_stall;
  assign out_free    = !out_valid || !out_stall;
  assign cur_live    = cur < count;
  assign hit         = rd_key == key_r;
  assign store_full  = count >= NONE;
  assign parent_none = parent == NONE;

  bstm_node_store #(
    .NODES      (NODES),
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS),
    .ADDR_W     (ADDR_W),
    .IDX_W      (IDX_W)
  ) u_store (
    .clk      (clk),
    .rd_en    (rd_en),
    .rd_addr  (cur[ADDR_W-1:0]),
    .rd_key   (rd_key),
    .rd_value (rd_value),
    .rd_left  (rd_left),
    .rd_right (rd_right),
    .wr       (wr),
    .wr_addr  (wr_addr),
    .wr_key   (key_r),
    .wr_value (value_r),
    .wr_child (wr_child)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_FETCH;
      end
      S_FETCH: begin
        if (cur_live) state_next = S_COMPARE;
        else if (op_r == OP_LOOKUP || store_full) state_next = S_DONE;
        else state_next = S_ATTACH;
      end
      S_COMPARE: begin
        state_next = hit ? S_DONE : S_FETCH;
      end
      S_ATTACH: begin
        state_next = parent_none ? S_DONE : S_LINK;
      end
      S_LINK: begin
        state_next = S_DONE;
      end
      S_DONE: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall = 1'b1;
    rd_en    = 1'b0;
    wr       = '0;
    wr_addr  = count[ADDR_W-1:0];
    wr_child = NONE;
    out_load = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_stall = 1'b0;
      end
      S_FETCH: begin
        rd_en = cur_live;
      end
      S_COMPARE: begin
      end
      S_ATTACH: begin
        // new leaf at the next free slot, both links empty
        wr = '{key_value: 1'b1, left: 1'b1, right: 1'b1};
      end
      S_LINK: begin
        wr_addr  = parent[ADDR_W-1:0];
        wr_child = count;
        wr.left  = go_left;
        wr.right = !go_left;
      end
      S_DONE: begin
        out_load = out_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      root      <= NONE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      if (state == S_ATTACH && parent_none) begin
        root  <= count;
        count <= count + 1'b1;
      end
      if (state == S_LINK) count <= count + 1'b1;
    end
  end

  // walk datapath
  always_ff @(posedge clk) begin
    if (in_take) begin
      op_r      <= operation;
      key_r     <= key;
      value_r   <= value;
      cur       <= root;
      parent    <= NONE;
      go_left   <= 1'b0;
      res_found <= 1'b0;
      res_value <= '0;
      res_full  <= 1'b0;
    end
    if (state == S_FETCH && !cur_live && op_r == OP_INSERT && store_full) begin
      res_full <= 1'b1;
    end
    if (state == S_COMPARE) begin
      if (hit) begin
        res_found <= 1'b1;
        res_value <= rd_value;
      end else begin
        parent  <= cur;
        go_left <= rd_key > key_r;
        cur     <= (rd_key > key_r) ? rd_left : rd_right;
      end
    end
    if (out_load) begin
      found        <= res_found;
      stored_value <= res_value;
      full_res     <= res_full;
    end
  end

endmodule

`default_nettype wire

// ===== sv/bstm_checker.sv =====
// ----------------------------------------------------------------------------
// bstm_checker
// port-level checks for the tree map, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bstm_checker #(
  parameter int KEY_BITS   = bstm_pkg::KEY_BITS_DEF,
  parameter int VALUE_BITS = bstm_pkg::VALUE_BITS_DEF
) (
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  in_valid,
  input wire logic                  in_stall,
  input wire logic                  operation,
  input wire logic [KEY_BITS-1:0]   key,
  input wire logic [VALUE_BITS-1:0] value,
  input wire logic                  out_valid,
  input wire logic                  out_stall,
  input wire logic                  found,
  input wire logic [VALUE_BITS-1:0] stored_value,
  input wire logic                  full_res
);
  import bstm_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable({found, stored_value, full_res}))
    else $error("stalled result changed");

  // busy after taking an item
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("item taken while walk in progress");

  // found and full never together
  a_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(found && full_res))
    else $error("found and full both set");

  // no value without a hit
  a_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |-> stored_value == '0)
    else $error("value reported on a miss");

endmodule

bind binary_search_tree_map_unit bstm_checker #(
  .KEY_BITS   (KEY_BITS),
  .VALUE_BITS (VALUE_BITS)
) u_bstm_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .operation    (operation),
  .key          (key),
  .value        (value),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .found        (found),
  .stored_value (stored_value),
  .full_res     (full_res)
);

`default_nettype wire
